@@ rtl/pjr_pkg.sv @@
// ----------------------------------------------------------------------------
// pjr_pkg
// Shared constants, codes and types of the Jacobi relaxation solver.
// ----------------------------------------------------------------------------
package pjr_pkg;

  // Grid and number formats
  localparam int GRID_MAX_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int ERR_W        = 63;
  localparam int H_W          = 24;
  localparam int CNT_W        = 16;
  localparam int GS_W         = 5;
  localparam int FRAC         = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_H    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd3;

  // Register reset values
  localparam logic [GS_W-1:0]  GS_RST    = 5'd16;
  localparam logic [H_W-1:0]   H_RST     = 24'd1048576;
  localparam logic [ERR_W-1:0] THR_RST   = 63'd281474977;
  localparam logic [CNT_W-1:0] MAXIT_RST = 16'hFFFF;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic    en;
    mul_op_t a;
    mul_op_t b;
  } mul_req_t;

endpackage

@@ rtl/pjr_mul.sv @@
// ----------------------------------------------------------------------------
// pjr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pjr_mul (
  input  logic              clk,
  input  pjr_pkg::mul_req_t req,
  output pjr_pkg::prod_t    prod_r
);

  // Capture the product when a request is issued, hold otherwise
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= pjr_pkg::PROD_W'(req.a) * pjr_pkg::PROD_W'(req.b);
    end
  end

endmodule

@@ rtl/poisson_jacobi_relaxation.sv @@
// ----------------------------------------------------------------------------
// poisson_jacobi_relaxation
// Jacobi relaxation solver for a 2D Poisson problem on a square grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one op per transfer: load stores
// one cell's source, Dirichlet data and Neumann fluxes; solve relaxes the grid;
// read returns one cell value. Result channel (out_valid / out_stall) gives one
// transfer per solve or read; a load gives none. Configuration goes through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write only while the block
// is idle, which the block does not enforce. A solve zeroes the current bank's
// cells in use, then per sweep visits GRID_MAX^2 cells: an interior cell in
// use steps through fetch, sort, side0-side3, src2, srca, new, sq and err,
// other cells through fetch and sort only, as set by the single value memory
// read port (self plus four neighbors) and the one shared multiplier (four
// fluxes, two source products, one square). One op is in work at a time;
// in_stall is high until it ends and during the clearing pass that zeroes
// values and flags after reset. The result waits in the output register
// while out_stall is high; the next op is taken meanwhile but cannot finish
// until the register is free.
// ----------------------------------------------------------------------------
module poisson_jacobi_relaxation #(
  parameter int GRID_MAX = pjr_pkg::GRID_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic [3:0]                           in_cell_x,
  input  logic [3:0]                           in_cell_y,
  input  logic signed [31:0]                   in_source_term,
  input  logic                                 in_fixed_flag,
  input  logic signed [31:0]                   in_fixed_value,
  input  logic [3:0]                           in_flux_mask,
  input  logic signed [31:0]                   in_flux_up,
  input  logic signed [31:0]                   in_flux_right,
  input  logic signed [31:0]                   in_flux_down,
  input  logic signed [31:0]                   in_flux_left,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_cell_value,
  output logic [15:0]                          out_sweep_count,
  output logic [62:0]                          out_final_error,
  output logic                                 out_converged,
  input  logic                                 cfg_wr_en,
  input  logic [pjr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pjr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_MAX);
  localparam int NW    = $clog2(GRID_MAX + 1);
  localparam int ACC_W = 37;
  localparam int VW    = pjr_pkg::VAL_W;
  localparam int EW    = pjr_pkg::ERR_W;
  localparam int MW    = pjr_pkg::MUL_W;

  localparam logic [XW-1:0] X_LAST = XW'(GRID_MAX - 1);

  localparam logic signed [ACC_W-1:0] VMAX = ACC_W'(32'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] VMIN = ACC_W'(32'sh80000000);

  // Controller states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_CELL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Per-cell steps
  localparam logic [3:0] STEP_FETCH = 4'd0;
  localparam logic [3:0] STEP_SORT  = 4'd1;
  localparam logic [3:0] STEP_SIDE0 = 4'd2;
  localparam logic [3:0] STEP_SIDE1 = 4'd3;
  localparam logic [3:0] STEP_SIDE2 = 4'd4;
  localparam logic [3:0] STEP_SIDE3 = 4'd5;
  localparam logic [3:0] STEP_SRC2  = 4'd6;
  localparam logic [3:0] STEP_SRCA  = 4'd7;
  localparam logic [3:0] STEP_NEW   = 4'd8;
  localparam logic [3:0] STEP_SQ    = 4'd9;
  localparam logic [3:0] STEP_ERR   = 4'd10;

  // Configuration registers
  logic [pjr_pkg::GS_W-1:0]  grid_size_r;
  logic [pjr_pkg::H_W-1:0]   step_h_r;
  logic [EW-1:0]             threshold_r;
  logic [pjr_pkg::CNT_W-1:0] max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= pjr_pkg::GS_RST;
      step_h_r    <= pjr_pkg::H_RST;
      threshold_r <= pjr_pkg::THR_RST;
      max_iter_r  <= pjr_pkg::MAXIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pjr_pkg::CFG_GRID_SIZE: grid_size_r <= cfg_wdata[pjr_pkg::GS_W-1:0];
        pjr_pkg::CFG_STEP_H:    step_h_r    <= cfg_wdata[pjr_pkg::H_W-1:0];
        pjr_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata[EW-1:0];
        pjr_pkg::CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[pjr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid size in use and sweep cap
  logic [NW-1:0]             n_use;
  logic [pjr_pkg::CNT_W-1:0] cap;

  always_comb begin
    if (int'(grid_size_r) < 2) begin
      n_use = NW'(2);
    end else if (int'(grid_size_r) > GRID_MAX) begin
      n_use = NW'(GRID_MAX);
    end else begin
      n_use = NW'(grid_size_r);
    end
    cap = (max_iter_r == '0) ? pjr_pkg::CNT_W'(1) : max_iter_r;
  end

  // Control and datapath registers
  logic [2:0]                state_r, state_nxt;
  logic [3:0]                step_r, step_nxt;
  logic [XW-1:0]             x_r, x_nxt, y_r, y_nxt;
  logic                      bank_r, bank_nxt;
  logic                      rd_inside_r, rd_inside_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [VW-1:0]      self_r, self_nxt;
  logic signed [VW-1:0]      nv_r, nv_nxt;
  logic [EW-1:0]             err_r, err_nxt;
  logic [pjr_pkg::CNT_W-1:0] sweep_r, sweep_nxt;
  logic signed [VW-1:0]      res_value_r, res_value_nxt;
  logic [pjr_pkg::CNT_W-1:0] res_sweep_r, res_sweep_nxt;
  logic [EW-1:0]             res_err_r, res_err_nxt;
  logic                      res_conv_r, res_conv_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]      out_value_r;
  logic [pjr_pkg::CNT_W-1:0] out_sweep_r;
  logic [EW-1:0]             out_err_r;
  logic                      out_conv_r;
  logic                      out_load;

  // Memory ports
  logic                      rd_val_en, rd_meta_en;
  logic [AW-1:0]             raddr;
  logic                      val_we0, val_we1;
  logic [AW-1:0]             val_waddr;
  logic signed [VW-1:0]      val_wdata;
  logic                      meta_we;
  logic [AW-1:0]             meta_waddr;
  logic [4:0]                meta_wdata;
  logic                      load_we;

  logic signed [VW-1:0]      val0_mem [CELLS];
  logic signed [VW-1:0]      val1_mem [CELLS];
  logic [4:0]                meta_mem [CELLS];
  logic signed [VW-1:0]      src_mem  [CELLS];
  logic signed [VW-1:0]      fix_mem  [CELLS];
  logic signed [VW-1:0]      flux_mem [4][CELLS];

  logic signed [VW-1:0]      val0_q, val1_q;
  logic [4:0]                meta_q;
  logic signed [VW-1:0]      src_q, fix_q;
  logic signed [VW-1:0]      flux_q [4];

  // Shared multiplier
  pjr_pkg::mul_req_t         mul_req;
  pjr_pkg::prod_t            prod_r;
  pjr_pkg::prod_t            prod_sar;

  pjr_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // Address and cell classification
  logic [AW-1:0]             cell_addr, nb_addr, in_addr;
  logic                      in_inside, in_accept, last_cell;
  logic                      in_region, on_edge;
  logic signed [VW-1:0]      rd_val;
  logic signed [ACC_W-1:0]   fl_sh, side_term, acc_sh;
  logic signed [VW-1:0]      nv_sat;
  logic signed [MW-1:0]      diff;
  logic [EW-1:0]             sq_sat, err_add, err_fin;
  logic [EW:0]               err_sum;
  logic [pjr_pkg::CNT_W-1:0] sweep_inc;
  logic [1:0]                side;
  logic [NW-1:0]             xe, ye;

  assign cell_addr = AW'(AW'(y_r) * AW'(GRID_MAX)) + AW'(x_r);
  assign in_inside = (int'(in_cell_x) < GRID_MAX) && (int'(in_cell_y) < GRID_MAX);
  assign in_addr   = AW'(AW'(in_cell_y) * AW'(GRID_MAX)) + AW'(in_cell_x);
  assign in_accept = in_valid && !in_stall;
  assign last_cell = (x_r == X_LAST) && (y_r == X_LAST);
  assign xe        = NW'(x_r);
  assign ye        = NW'(y_r);
  assign in_region = (xe < n_use) && (ye < n_use);
  assign on_edge   = (x_r == '0) || (y_r == '0) || (xe == n_use - NW'(1)) ||
                     (ye == n_use - NW'(1));
  assign rd_val    = bank_r ? val1_q : val0_q;

  // Neighbor address for the side issued at this step
  always_comb begin
    case (step_r)
      STEP_SORT:  nb_addr = cell_addr - AW'(GRID_MAX);
      STEP_SIDE0: nb_addr = cell_addr + AW'(1);
      STEP_SIDE1: nb_addr = cell_addr + AW'(GRID_MAX);
      default:    nb_addr = cell_addr - AW'(1);
    endcase
  end

  // Stencil arithmetic
  assign prod_sar  = prod_r >>> pjr_pkg::FRAC;
  assign fl_sh     = prod_sar[ACC_W-1:0];
  assign side      = 2'(step_r - STEP_SIDE0);
  assign side_term = meta_q[side] ? (ACC_W'(self_r) - fl_sh) : ACC_W'(rd_val);
  assign acc_sh    = acc_r >>> 2;
  assign nv_sat    = (acc_sh > VMAX) ? VMAX[VW-1:0] :
                     (acc_sh < VMIN) ? VMIN[VW-1:0] : acc_sh[VW-1:0];
  assign diff      = MW'(self_r) - MW'(nv_r);
  assign sq_sat    = (prod_r[pjr_pkg::PROD_W-1:EW] != '0) ? pjr_pkg::ERR_MAX :
                     prod_r[EW-1:0];
  assign err_sum   = {1'b0, err_r} + {1'b0, sq_sat};
  assign err_add   = err_sum[EW] ? pjr_pkg::ERR_MAX : err_sum[EW-1:0];
  assign err_fin   = (step_r == STEP_ERR) ? err_add : err_r;
  assign sweep_inc = sweep_r + pjr_pkg::CNT_W'(1);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    bank_nxt      = bank_r;
    rd_inside_nxt = rd_inside_r;
    acc_nxt       = acc_r;
    self_nxt      = self_r;
    nv_nxt        = nv_r;
    err_nxt       = err_r;
    sweep_nxt     = sweep_r;
    res_value_nxt = res_value_r;
    res_sweep_nxt = res_sweep_r;
    res_err_nxt   = res_err_r;
    res_conv_nxt  = res_conv_r;
    rd_val_en     = 1'b0;
    rd_meta_en    = 1'b0;
    raddr         = cell_addr;
    val_we0       = 1'b0;
    val_we1       = 1'b0;
    val_waddr     = cell_addr;
    val_wdata     = '0;
    meta_we       = 1'b0;
    meta_waddr    = cell_addr;
    meta_wdata    = '0;
    load_we       = 1'b0;
    mul_req.en    = 1'b0;
    mul_req.a     = MW'(step_h_r);
    mul_req.b     = MW'(flux_q[0]);

    case (state_r)
      // Zero both value banks and the flag memory, one cell a cycle
      ST_CLEAR: begin
        val_we0 = 1'b1;
        val_we1 = 1'b1;
        meta_we = 1'b1;
        x_nxt   = x_r + XW'(1);
        if (x_r == X_LAST) begin
          x_nxt = '0;
          y_nxt = y_r + XW'(1);
        end
        if (last_cell) begin
          y_nxt     = '0;
          bank_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            pjr_pkg::OP_LOAD: begin
              meta_we    = in_inside;
              load_we    = in_inside;
              meta_waddr = in_addr;
              meta_wdata = {in_fixed_flag, in_flux_mask};
            end
            pjr_pkg::OP_SOLVE: begin
              x_nxt     = '0;
              y_nxt     = '0;
              state_nxt = ST_ZERO;
            end
            pjr_pkg::OP_READ: begin
              rd_val_en     = in_inside;
              raddr         = in_addr;
              rd_inside_nxt = in_inside;
              state_nxt     = ST_READ;
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        res_value_nxt = rd_inside_r ? rd_val : '0;
        res_sweep_nxt = '0;
        res_err_nxt   = '0;
        res_conv_nxt  = 1'b0;
        state_nxt     = ST_DONE;
      end

      // Zero the values in use in the current bank
      ST_ZERO: begin
        val_we0 = in_region && !bank_r;
        val_we1 = in_region && bank_r;
        x_nxt   = x_r + XW'(1);
        if (x_r == X_LAST) begin
          x_nxt = '0;
          y_nxt = y_r + XW'(1);
        end
        if (last_cell) begin
          y_nxt     = '0;
          step_nxt  = STEP_FETCH;
          err_nxt   = '0;
          sweep_nxt = '0;
          state_nxt = ST_CELL;
        end
      end

      ST_CELL: begin
        case (step_r)
          STEP_FETCH: begin
            rd_val_en  = 1'b1;
            rd_meta_en = 1'b1;
            step_nxt   = STEP_SORT;
          end
          STEP_SORT: begin
            self_nxt = rd_val;
            if (in_region && !meta_q[4] && !on_edge) begin
              acc_nxt    = '0;
              rd_val_en  = 1'b1;
              raddr      = nb_addr;
              mul_req.en = 1'b1;
              mul_req.b  = MW'(flux_q[0]);
              step_nxt   = STEP_SIDE0;
            end else begin
              val_wdata = (in_region && meta_q[4]) ? fix_q : rd_val;
              val_we0   = bank_r;
              val_we1   = !bank_r;
            end
          end
          STEP_SIDE0, STEP_SIDE1, STEP_SIDE2, STEP_SIDE3: begin
            acc_nxt    = acc_r + side_term;
            mul_req.en = 1'b1;
            if (step_r == STEP_SIDE3) begin
              mul_req.b = MW'(src_q);
            end else begin
              rd_val_en = 1'b1;
              raddr     = nb_addr;
              mul_req.b = MW'(flux_q[2'(side + 2'd1)]);
            end
            step_nxt = step_r + 4'd1;
          end
          STEP_SRC2: begin
            mul_req.en = 1'b1;
            mul_req.b  = prod_sar[MW-1:0];
            step_nxt   = STEP_SRCA;
          end
          STEP_SRCA: begin
            acc_nxt  = acc_r + fl_sh;
            step_nxt = STEP_NEW;
          end
          STEP_NEW: begin
            nv_nxt    = nv_sat;
            val_wdata = nv_sat;
            val_we0   = bank_r;
            val_we1   = !bank_r;
            step_nxt  = STEP_SQ;
          end
          STEP_SQ: begin
            mul_req.en = 1'b1;
            mul_req.a  = diff;
            mul_req.b  = diff;
            step_nxt   = STEP_ERR;
          end
          default: begin
            err_nxt = err_add;
          end
        endcase

        // Advance to the next cell, or close the sweep
        if ((step_r == STEP_ERR) ||
            ((step_r == STEP_SORT) && !(in_region && !meta_q[4] && !on_edge))) begin
          step_nxt = STEP_FETCH;
          x_nxt    = x_r + XW'(1);
          if (x_r == X_LAST) begin
            x_nxt = '0;
            y_nxt = y_r + XW'(1);
          end
          if (last_cell) begin
            y_nxt     = '0;
            bank_nxt  = !bank_r;
            sweep_nxt = sweep_inc;
            if ((err_fin >= threshold_r) && (sweep_inc < cap)) begin
              err_nxt = '0;
            end else begin
              err_nxt       = err_fin;
              res_value_nxt = '0;
              res_sweep_nxt = sweep_inc;
              res_err_nxt   = err_fin;
              res_conv_nxt  = (err_fin < threshold_r);
              state_nxt     = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drop the result after its transfer, load a new one when free
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= STEP_FETCH;
      x_r         <= '0;
      y_r         <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
      err_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r     <= sweep_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_inside_r <= rd_inside_nxt;
    acc_r       <= acc_nxt;
    self_r      <= self_nxt;
    nv_r        <= nv_nxt;
    res_value_r <= res_value_nxt;
    res_sweep_r <= res_sweep_nxt;
    res_err_r   <= res_err_nxt;
    res_conv_r  <= res_conv_nxt;
    if (out_load) begin
      out_value_r <= res_value_r;
      out_sweep_r <= res_sweep_r;
      out_err_r   <= res_err_r;
      out_conv_r  <= res_conv_r;
    end
  end

  // Value banks: write one cell, read one cell with registered data
  always_ff @(posedge clk) begin
    if (val_we0) begin
      val0_mem[val_waddr] <= val_wdata;
    end
    if (val_we1) begin
      val1_mem[val_waddr] <= val_wdata;
    end
    if (rd_val_en) begin
      val0_q <= val0_mem[raddr];
      val1_q <= val1_mem[raddr];
    end
  end

  // Cell data memories
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (load_we) begin
      src_mem[meta_waddr]     <= in_source_term;
      fix_mem[meta_waddr]     <= in_fixed_value;
      flux_mem[0][meta_waddr] <= in_flux_up;
      flux_mem[1][meta_waddr] <= in_flux_right;
      flux_mem[2][meta_waddr] <= in_flux_down;
      flux_mem[3][meta_waddr] <= in_flux_left;
    end
    if (rd_meta_en) begin
      meta_q    <= meta_mem[raddr];
      src_q     <= src_mem[raddr];
      fix_q     <= fix_mem[raddr];
      flux_q[0] <= flux_mem[0][raddr];
      flux_q[1] <= flux_mem[1][raddr];
      flux_q[2] <= flux_mem[2][raddr];
      flux_q[3] <= flux_mem[3][raddr];
    end
  end

  // Outputs
  assign out_valid       = out_valid_r;
  assign out_cell_value  = out_value_r;
  assign out_sweep_count = out_sweep_r;
  assign out_final_error = out_err_r;
  assign out_converged   = out_conv_r;

  // Checks
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> state_r == ST_CLEAR)
    else $error("clearing pass not started after reset");

  a_no_current_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CELL |-> !(bank_r ? val_we1 : val_we0))
    else $error("sweep wrote the bank it reads");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CELL |-> step_r <= STEP_ERR)
    else $error("cell step out of range");

  a_sweep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> res_sweep_r <= cap)
    else $error("sweep count beyond cap");

  a_converged_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_conv_r) |-> res_err_r < threshold_r)
    else $error("converged flag with error at or above threshold");

endmodule
